// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Each use stands on a line of its own and gives a label, the clock, the
// active-low reset, an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("timer table check failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("timer table check failed: next-cycle implication");

`endif

// File: hw/rtl/ost_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ost_pkg;

    localparam int TimersDefault = 16;
    localparam int MaxFire       = 16;

    localparam int OpW  = 2;
    localparam int DurW = 31;
    localparam int IdW  = 16;
    localparam int DlW  = 32;

    localparam int InTdataW    = 56;
    localparam int OutFieldsW  = 68;
    localparam int OutTdataW   = 72;
    localparam int OutPadW     = OutTdataW - OutFieldsW;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_REFRESH = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_TICK    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_EMIT
    } state_t;

    // One armed timer as held in the table memory.
    typedef struct packed {
        logic [DlW-1:0]  deadline;
        logic [DurW-1:0] length;
        logic [IdW-1:0]  ident;
    } entry_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
        logic advance;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic res_last;
    } sts_t;

    typedef struct packed {
        logic [IdW-1:0] gid;
        logic           full;
        logic           found;
        logic           wake;
        logic           fired;
        logic [IdW-1:0] fid;
        logic           ev;
        logic [DlW-1:0] edl;
        logic           last;
    } res_t;

    // Wrapping time compare: a lies before b.
    function automatic logic is_before(input logic [DlW-1:0] a, input logic [DlW-1:0] b);
        logic [DlW-1:0] d;
        d = a - b;
        return d[DlW-1];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ost_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ost_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ost_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ost_ctrl
    import ost_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    input  wire logic m_tready,
    input  wire sts_t sts,
    output logic      s_tready,
    output logic      m_tvalid,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (sts.scan_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_tready && sts.res_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd         = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
            end
            ST_EMIT: begin
                m_tvalid    = 1'b1;
                cmd.advance = m_tready && !sts.res_last;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/ost_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module ost_datapath
    import ost_pkg::*;
#(
    parameter int TIMERS = TimersDefault
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire cmd_t            cmd,
    input  wire logic [OpW-1:0]  in_op,
    input  wire logic [DurW-1:0] in_dur,
    input  wire logic [IdW-1:0]  in_id,
    output sts_t                 sts,
    output res_t                 res
);

    localparam int AW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CW = $clog2(TIMERS + 1);
    localparam int FW = $clog2(MaxFire + 1);
    localparam int BW = $clog2(MaxFire);
    localparam int EW = $bits(entry_t);

    op_t             op_reg, op_next;
    logic [DurW-1:0] dur_reg, dur_next;
    logic [IdW-1:0]  id_reg, id_next;
    logic [DlW-1:0]  now_reg, now_next;
    logic [IdW-1:0]  next_id_reg, next_id_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   rd_idx_reg, rd_idx_next;
    logic [CW-1:0]   wr_idx_reg, wr_idx_next;
    logic            pv_reg, pv_next;
    logic            prev_have_reg, prev_have_next;
    logic [DlW-1:0]  prev_best_reg, prev_best_next;
    logic            aft_have_reg, aft_have_next;
    logic [DlW-1:0]  aft_best_reg, aft_best_next;
    logic            hit_reg, hit_next;
    logic [DlW-1:0]  new_dl_reg, new_dl_next;
    logic [FW-1:0]   fire_cnt_reg, fire_cnt_next;
    logic [FW-1:0]   out_idx_reg, out_idx_next;
    res_t            res_reg, res_next;
    logic [IdW-1:0]  fire_buf_reg [MaxFire];

    logic            fb_we;
    logic [IdW-1:0]  fb_wdata;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    entry_t          ram_wdata;
    logic            ram_re;
    logic [EW-1:0]   ram_rdata;

    entry_t          ent;
    entry_t          cur;
    logic            keep;
    logic            add_wake;
    logic [IdW-1:0]  id_inc;

    ost_ram #(
        .WIDTH (EW),
        .DEPTH (TIMERS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg      <= '0;
            next_id_reg  <= IdW'(1);
            count_reg    <= '0;
            rd_idx_reg   <= '0;
            wr_idx_reg   <= '0;
            pv_reg       <= 1'b0;
            fire_cnt_reg <= '0;
            out_idx_reg  <= '0;
        end else begin
            now_reg      <= now_next;
            next_id_reg  <= next_id_next;
            count_reg    <= count_next;
            rd_idx_reg   <= rd_idx_next;
            wr_idx_reg   <= wr_idx_next;
            pv_reg       <= pv_next;
            fire_cnt_reg <= fire_cnt_next;
            out_idx_reg  <= out_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        dur_reg       <= dur_next;
        id_reg        <= id_next;
        prev_have_reg <= prev_have_next;
        prev_best_reg <= prev_best_next;
        aft_have_reg  <= aft_have_next;
        aft_best_reg  <= aft_best_next;
        hit_reg       <= hit_next;
        new_dl_reg    <= new_dl_next;
        res_reg       <= res_next;
        if (fb_we) begin
            fire_buf_reg[fire_cnt_reg[BW-1:0]] <= fb_wdata;
        end
    end

    always_comb begin
        op_next        = op_reg;
        dur_next       = dur_reg;
        id_next        = id_reg;
        now_next       = now_reg;
        next_id_next   = next_id_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        pv_next        = pv_reg;
        prev_have_next = prev_have_reg;
        prev_best_next = prev_best_reg;
        aft_have_next  = aft_have_reg;
        aft_best_next  = aft_best_reg;
        hit_next       = hit_reg;
        new_dl_next    = new_dl_reg;
        fire_cnt_next  = fire_cnt_reg;
        out_idx_next   = out_idx_reg;
        res_next       = res_reg;
        fb_we          = 1'b0;
        fb_wdata       = '0;
        ram_we         = 1'b0;
        ram_waddr      = wr_idx_reg[AW-1:0];
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ent            = entry_t'(ram_rdata);
        cur            = ent;
        keep           = 1'b1;
        add_wake       = !aft_have_reg || is_before(new_dl_reg, aft_best_reg);
        id_inc         = next_id_reg + IdW'(1);

        if (cmd.load) begin
            op_next        = op_t'(in_op);
            dur_next       = in_dur;
            id_next        = in_id;
            now_next       = (op_t'(in_op) == OP_TICK) ? now_reg + DlW'(1) : now_reg;
            new_dl_next    = now_reg + {1'b0, in_dur};
            rd_idx_next    = '0;
            wr_idx_next    = '0;
            pv_next        = 1'b0;
            prev_have_next = 1'b0;
            prev_best_next = '0;
            aft_have_next  = 1'b0;
            aft_best_next  = '0;
            hit_next       = 1'b0;
            fire_cnt_next  = '0;
        end

        if (cmd.scan) begin
            // Issue the next read while the previous entry is being processed.
            pv_next = (rd_idx_reg != count_reg);
            if (rd_idx_reg != count_reg) begin
                ram_re      = 1'b1;
                rd_idx_next = rd_idx_reg + CW'(1);
            end
            if (pv_reg) begin
                if (!prev_have_reg || is_before(ent.deadline, prev_best_reg)) begin
                    prev_have_next = 1'b1;
                    prev_best_next = ent.deadline;
                end
                case (op_reg)
                    OP_REFRESH: begin
                        if (!hit_reg && ent.ident == id_reg) begin
                            cur.deadline = now_reg + {1'b0, ent.length};
                            hit_next     = 1'b1;
                            new_dl_next  = cur.deadline;
                        end
                    end
                    OP_REMOVE: begin
                        if (id_reg != '0 && ent.ident == id_reg) begin
                            keep     = 1'b0;
                            hit_next = 1'b1;
                        end
                    end
                    OP_TICK: begin
                        if (fire_cnt_reg < FW'(MaxFire) && is_before(ent.deadline, now_reg)) begin
                            keep          = 1'b0;
                            fb_we         = 1'b1;
                            fb_wdata      = ent.ident;
                            fire_cnt_next = fire_cnt_reg + FW'(1);
                        end
                    end
                    default: begin
                        keep = 1'b1;
                    end
                endcase
                if (keep) begin
                    ram_we      = 1'b1;
                    ram_wdata   = cur;
                    wr_idx_next = wr_idx_reg + CW'(1);
                    if (!aft_have_reg || is_before(cur.deadline, aft_best_reg)) begin
                        aft_have_next = 1'b1;
                        aft_best_next = cur.deadline;
                    end
                end
            end
        end

        if (cmd.finish) begin
            res_next       = '0;
            res_next.ev    = aft_have_reg;
            res_next.edl   = aft_best_reg;
            res_next.last  = 1'b1;
            count_next     = wr_idx_reg;
            out_idx_next   = FW'(1);
            case (op_reg)
                OP_ADD: begin
                    if (count_reg == CW'(TIMERS)) begin
                        res_next.full = 1'b1;
                    end else begin
                        ram_we           = 1'b1;
                        ram_waddr        = count_reg[AW-1:0];
                        ram_wdata        = '{deadline: new_dl_reg, length: dur_reg,
                                             ident: next_id_reg};
                        count_next       = count_reg + CW'(1);
                        next_id_next     = (id_inc == '0) ? IdW'(1) : id_inc;
                        res_next.gid     = next_id_reg;
                        res_next.wake    = add_wake;
                        res_next.ev      = 1'b1;
                        res_next.edl     = add_wake ? new_dl_reg : aft_best_reg;
                    end
                end
                OP_REFRESH: begin
                    res_next.found = hit_reg;
                    res_next.wake  = hit_reg &&
                                     (!prev_have_reg || is_before(new_dl_reg, prev_best_reg));
                end
                OP_REMOVE: begin
                    res_next.found = hit_reg;
                end
                OP_TICK: begin
                    if (fire_cnt_reg != '0) begin
                        res_next.fired = 1'b1;
                        res_next.fid   = fire_buf_reg[0];
                        res_next.last  = (fire_cnt_reg == FW'(1));
                    end
                end
                default: begin
                    res_next.last = 1'b1;
                end
            endcase
        end

        if (cmd.advance) begin
            res_next.fid  = fire_buf_reg[out_idx_reg[BW-1:0]];
            res_next.last = ((out_idx_reg + FW'(1)) == fire_cnt_reg);
            out_idx_next  = out_idx_reg + FW'(1);
        end
    end

    assign sts.scan_done = (rd_idx_reg == count_reg) && !pv_reg;
    assign sts.res_last  = res_reg.last;
    assign res           = res_reg;

endmodule

`default_nettype wire

// File: hw/rtl/one_shot_timer_table.sv
`timescale 1ns / 1ps
`default_nettype none
// The table is swept one entry per cycle, over the armed timers, between the input beat
// and the first result beat. A new operation is taken only once the last result beat of
// the previous one has been accepted; a tick gives one beat per fired timer (a single
// beat if none fired), every other operation a single beat.
// Reset: synchronous, active low; time returns to zero, the table is emptied and ids
// restart at one. No clearing pass runs, so the block is ready straight after reset.

module one_shot_timer_table
    import ost_pkg::*;
#(
    parameter int TIMERS = TimersDefault
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Operations in.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // From bit 0: op (2), duration (31), timer_id (16), zero fill (7).
    input  wire logic [InTdataW-1:0]  s_tdata,
    // Results out.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // From bit 0: given_id (16), table_full, found, wake, fired_id (16),
    // earliest_valid, earliest_deadline (32), zero fill (4).
    output logic [OutTdataW-1:0]      m_tdata,
    // Bit 0: fired.
    output logic [0:0]                m_tuser,
    output logic                      m_tlast
);

    // The controller sequences each operation through a sweep of the table,
    // a finishing step that commits counts and, for an add, appends a new timer, and the
    // result beats. Timers are held compacted in insertion order, so the sweep
    // both filters out removed or fired timers and finds the earliest deadline.
    cmd_t cmd;
    sts_t sts;
    res_t res;

    ost_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    ost_datapath #(
        .TIMERS (TIMERS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .in_op   (s_tdata[OpW-1:0]),
        .in_dur  (s_tdata[OpW+DurW-1:OpW]),
        .in_id   (s_tdata[OpW+DurW+IdW-1:OpW+DurW]),
        .sts     (sts),
        .res     (res)
    );

    // Pack the result beat, lowest field first.
    assign m_tdata = {{OutPadW{1'b0}}, res.edl, res.ev, res.fid,
                      res.wake, res.found, res.full, res.gid};
    assign m_tuser = res.fired;
    assign m_tlast = res.last;

endmodule

`default_nettype wire

// File: hw/rtl/ost_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ost_checker
    import ost_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [OutTdataW-1:0] m_tdata,
    input wire logic [0:0]           m_tuser,
    input wire logic                 m_tlast
);

    // An accepted operation always needs a sweep before any result appears.
    `ASSERT_NXT(a_accept_then_busy, aclk, aresetn, s_tvalid && s_tready, !m_tvalid)
    // A stalled result beat holds its data.
    `ASSERT_NXT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    // Only a firing can be followed by more beats of the same operation.
    `ASSERT_IMP(a_single_result, aclk, aresetn, m_tvalid && !m_tuser[0], m_tlast)
    // A firing beat carries no add, refresh or remove status.
    `ASSERT_IMP(a_fire_clean, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[18:0] == 19'd0)
    // No armed timer means a zero deadline, and a refused add has no id.
    `ASSERT_IMP(a_empty_zero, aclk, aresetn, m_tvalid && (!m_tdata[35] || m_tdata[16]), (m_tdata[35] || m_tdata[67:36] == 32'd0) && (!m_tdata[16] || m_tdata[15:0] == 16'd0))

endmodule

bind one_shot_timer_table ost_checker u_ost_checker (.*);

`default_nettype wire
